>>> design/tccw_pkg.sv
// Package for the text console cell writer: codes, defaults and the state type.
package tccw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'd32;
  localparam logic [15:0] RESET_CELL   = 16'h0720;
  localparam logic [7:0]  RESET_COLOR  = 8'd7;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration port geometry and register index.
  localparam int   CFG_AW             = 3;
  localparam logic REG_IDX_TEXT_COLOR = 1'b0;

  localparam int POS_W   = 11;
  localparam int CELL_W  = 16;
  localparam int WIDE_W  = 13;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCROLL,
    S_DIV,
    S_RD,
    S_RDW
  } state_t;

endpackage

>>> design/text_console_cell_writer_top.sv
// Text console cell writer: cell store with circular row base, cursor and APB colour register.
//
// Items arrive on the in_ channel (tuser = operation, tdata = char_code and read_index)
// and each gives exactly one result beat on the out_ channel (cursor_pos, cell_data,
// scrolled). The attribute byte for new cells is written over the cfg_ APB port.
// Cells live in one synchronous memory addressed by {physical row, column}; a scroll
// only advances the top-row pointer and rewrites the freed row with spaces.
// Work per item, set by the single memory write port and the row split of a read:
//   put without scroll: result registered at the accept edge;
//   put with scroll: result after the new bottom row is cleared;
//   read: the reciprocal row split (S_DIV), then the memory read (S_RD, S_RDW);
//   read beyond the store: result registered at the accept edge.
// One item is in work at a time; the result register lets the next item be taken
// in the cycle in which the previous result beat is taken.
// After reset the block sweeps the store to grey spaces with in_tready low; the
// cursor resets to the top left and the colour to 7.
// When the receiver stalls, the result is held and no new item is accepted.
module text_console_cell_writer_top
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [23:0]         in_tdata,   // char_code[7:0], read_index[18:8], zero pad
  input  logic [0:0]          in_tuser,   // operation[0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // cursor_pos[10:0], cell_data[26:11], scrolled[27]
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int CW         = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW         = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int AW         = RW + CW;
  localparam int MEM_DEPTH  = 1 << AW;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int RECIP_SH   = 24;
  localparam int PROD_W     = POS_W + RECIP_SH;

  localparam logic [CW-1:0]       LAST_COL   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]       LAST_ROW   = RW'(ROWS - 1);
  localparam logic [CW:0]         COLS_EXT   = (CW + 1)'(COLUMNS);
  localparam logic [WIDE_W-1:0]   CELLS_WIDE = WIDE_W'(CELL_COUNT);
  // Rounded-up reciprocal of COLUMNS; exact for every 11-bit index.
  localparam logic [RECIP_SH-1:0] RECIP      =
    RECIP_SH'(((1 << RECIP_SH) + COLUMNS - 1) / COLUMNS);

  state_t              state_r, state_nxt;
  logic [RW-1:0]       cursor_row_r, cursor_row_nxt;
  logic [CW-1:0]       cursor_col_r, cursor_col_nxt;
  logic [RW-1:0]       cur_prow_r, cur_prow_nxt;
  logic [RW-1:0]       top_r, top_nxt;
  logic [RW-1:0]       clr_row_r, clr_row_nxt;
  logic [CW-1:0]       clr_col_r, clr_col_nxt;
  logic [7:0]          text_color_r;
  logic [POS_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [RW-1:0]       div_q_r, div_q_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]    out_pos_r;
  logic [CELL_W-1:0]   out_cell_r;
  logic                out_scr_r;

  logic [CELL_W-1:0]   cells_mem [MEM_DEPTH];
  logic [CELL_W-1:0]   mem_rdata_r;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [CELL_W-1:0]   mem_wdata;

  logic                in_fire, load_out, load_scr, wrap;
  logic [CELL_W-1:0]   load_cell;
  logic                op;
  logic [7:0]          char_code;
  logic [POS_W-1:0]    read_index;
  logic [WIDE_W-1:0]   pos_wide;
  logic [PROD_W-1:0]   div_prod;
  logic [POS_W-1:0]    rd_col_wide;
  logic [CW-1:0]       rd_col;
  logic [RW:0]         rd_prow_sum;
  logic [RW-1:0]       rd_prow;
  logic                cfg_wr;

  assign op         = in_tuser[0];
  assign char_code  = in_tdata[7:0];
  assign read_index = in_tdata[18:8];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign wrap      = (({1'b0, cursor_col_r} + (CW + 1)'(1)) == COLS_EXT) ||
                     (char_code == NEWLINE_CODE);

  // Row of a read is the index times the reciprocal, scaled back down.
  assign div_prod    = PROD_W'(rd_idx_r) * PROD_W'(RECIP);
  assign rd_col_wide = rd_idx_r - POS_W'(div_q_r) * POS_W'(COLUMNS);
  assign rd_col      = rd_col_wide[CW-1:0];

  // Physical row of a read: quotient plus the top-row base, modulo ROWS.
  assign rd_prow_sum = {1'b0, div_q_r} + {1'b0, top_r};
  assign rd_prow     = (rd_prow_sum >= (RW + 1)'(ROWS)) ?
                       RW'(rd_prow_sum - (RW + 1)'(ROWS)) : rd_prow_sum[RW-1:0];

  assign pos_wide = WIDE_W'(cursor_row_nxt) * WIDE_W'(COLUMNS) + WIDE_W'(cursor_col_nxt);

  always_comb begin
    state_nxt      = state_r;
    cursor_row_nxt = cursor_row_r;
    cursor_col_nxt = cursor_col_r;
    cur_prow_nxt   = cur_prow_r;
    top_nxt        = top_r;
    clr_row_nxt    = clr_row_r;
    clr_col_nxt    = clr_col_r;
    rd_idx_nxt     = rd_idx_r;
    div_q_nxt      = div_q_r;
    mem_we         = 1'b0;
    mem_waddr      = {clr_row_r, clr_col_r};
    mem_wdata      = RESET_CELL;
    mem_re         = 1'b0;
    mem_raddr      = {rd_prow, rd_col};
    load_out       = 1'b0;
    load_scr       = 1'b0;
    load_cell      = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_col_r == LAST_COL) begin
          clr_col_nxt = '0;
          if (clr_row_r == LAST_ROW) begin
            clr_row_nxt = '0;
            state_nxt   = S_IDLE;
          end else begin
            clr_row_nxt = clr_row_r + RW'(1);
          end
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (op == OP_READ) begin
            if (WIDE_W'(read_index) < CELLS_WIDE) begin
              rd_idx_nxt = read_index;
              state_nxt  = S_DIV;
            end else begin
              load_out = 1'b1;
            end
          end else begin
            if (char_code != NEWLINE_CODE) begin
              mem_we    = 1'b1;
              mem_waddr = {cur_prow_r, cursor_col_r};
              mem_wdata = {text_color_r, char_code};
            end
            if (!wrap) begin
              cursor_col_nxt = cursor_col_r + CW'(1);
              load_out       = 1'b1;
            end else begin
              cursor_col_nxt = '0;
              if (cursor_row_r == LAST_ROW) begin
                // The old top row becomes the new bottom row and is cleared.
                top_nxt      = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
                cur_prow_nxt = top_r;
                clr_row_nxt  = top_r;
                clr_col_nxt  = '0;
                state_nxt    = S_SCROLL;
              end else begin
                cursor_row_nxt = cursor_row_r + RW'(1);
                cur_prow_nxt   = (cur_prow_r == LAST_ROW) ? '0 : cur_prow_r + RW'(1);
                load_out       = 1'b1;
              end
            end
          end
        end
      end
      S_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = {text_color_r, SPACE_CODE};
        if (clr_col_r == LAST_COL) begin
          clr_col_nxt = '0;
          clr_row_nxt = '0;
          load_out    = 1'b1;
          load_scr    = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          clr_col_nxt = clr_col_r + CW'(1);
        end
      end
      S_DIV: begin
        div_q_nxt = div_prod[RECIP_SH +: RW];
        state_nxt = S_RD;
      end
      S_RD: begin
        mem_re    = 1'b1;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        load_out  = 1'b1;
        load_cell = mem_rdata_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cursor_row_r <= '0;
      cursor_col_r <= '0;
      cur_prow_r   <= '0;
      top_r        <= '0;
      clr_row_r    <= '0;
      clr_col_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cursor_row_r <= cursor_row_nxt;
      cursor_col_r <= cursor_col_nxt;
      cur_prow_r   <= cur_prow_nxt;
      top_r        <= top_nxt;
      clr_row_r    <= clr_row_nxt;
      clr_col_r    <= clr_col_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
    div_q_r  <= div_q_nxt;
    if (load_out) begin
      out_pos_r  <= pos_wide[POS_W-1:0];
      out_cell_r <= load_cell;
      out_scr_r  <= load_scr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= cells_mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_scr_r, out_cell_r, out_pos_r};

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[CFG_AW-1:2] == REG_IDX_TEXT_COLOR);
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_IDX_TEXT_COLOR) ?
                      {24'b0, text_color_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_wr) begin
      text_color_r <= cfg_pwdata[7:0];
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cursor_row_r <= LAST_ROW) && (cursor_col_r <= LAST_COL))
    else $error("cursor outside the screen");

  a_prow_tracks_base: assert property (@(posedge clk) disable iff (!rst_n)
    ((({1'b0, cursor_row_r} + {1'b0, top_r}) == {1'b0, cur_prow_r}) ||
     (({1'b0, cursor_row_r} + {1'b0, top_r}) == ({1'b0, cur_prow_r} + (RW + 1)'(ROWS)))))
    else $error("physical cursor row out of step with the row base");

  a_accept_gives_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (out_valid_r || (state_r != S_IDLE)))
    else $error("accepted beat produced neither a result nor work");

  a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCROLL) |-> (cursor_row_r == LAST_ROW) && (cursor_col_r == '0))
    else $error("row clear running while cursor is not at the bottom line start");

endmodule

>>> bench/text_console_cell_writer_checker.sv
// Checker for the text console cell writer: tracks the screen and cursor, predicts each result beat and compares.
module text_console_cell_writer_checker
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,   // char_code[7:0], read_index[18:8], zero pad
  input  logic [0:0]        in_tuser,   // operation[0]
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [31:0]       out_tdata,  // cursor_pos[10:0], cell_data[26:11], scrolled[27]
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [CELL_W-1:0] cdata;
    logic              scrolled;
  } console_beat_t;

  logic [CELL_W-1:0] screen [CELLS];
  int unsigned       cur_row;
  int unsigned       cur_col;
  logic [7:0]        colour;
  console_beat_t     awaited [$];

  function automatic void log_miss(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t checker: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    end
  endfunction

  // Applies one beat to the screen and cursor and returns the beat the block should send.
  function automatic console_beat_t console_step(input logic op, input logic [7:0] ch,
                                                 input logic [POS_W-1:0] idx);
    console_beat_t r;
    int i;
    r = '0;
    if (op == OP_READ) begin
      if (idx < CELLS) begin
        r.cdata = screen[idx];
      end
    end else begin
      if (ch != NEWLINE_CODE) begin
        screen[cur_row * COLUMNS + cur_col] = {colour, ch};
      end
      cur_col++;
      if (cur_col == COLUMNS || ch == NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
        if (cur_row == ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) begin
            screen[i] = screen[i + COLUMNS];
          end
          for (i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen[i] = {colour, SPACE_CODE};
          end
          cur_row    = ROWS - 1;
          r.scrolled = 1'b1;
        end
      end
    end
    r.pos = POS_W'(cur_row * COLUMNS + cur_col);
    return r;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin : watch
    console_beat_t want;
    console_beat_t got;
    int i;
    if (!rst_n) begin
      for (i = 0; i < CELLS; i++) begin
        screen[i] = RESET_CELL;
      end
      cur_row = 0;
      cur_col = 0;
      colour  = RESET_COLOR;
      awaited.delete();
      pending <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready
          && int'(cfg_paddr >> 2) == int'(REG_IDX_TEXT_COLOR)) begin
        if (cfg_pwrite) begin
          colour = cfg_pwdata[7:0];
        end else if (cfg_prdata !== {24'b0, colour}) begin
          log_miss("text_color read-back", {24'b0, colour}, cfg_prdata);
        end
      end
      if (out_tvalid && out_tready) begin
        got.pos      = out_tdata[10:0];
        got.cdata    = out_tdata[26:11];
        got.scrolled = out_tdata[27];
        if (awaited.size() == 0) begin
          log_miss("result beat with nothing outstanding, tdata", 32'b0, out_tdata);
        end else begin
          want = awaited.pop_front();
          if (got.pos !== want.pos) log_miss("cursor_pos", want.pos, got.pos);
          if (got.cdata !== want.cdata) log_miss("cell_data", want.cdata, got.cdata);
          if (got.scrolled !== want.scrolled) log_miss("scrolled", want.scrolled, got.scrolled);
        end
      end
      if (in_tvalid && in_tready) begin
        awaited.push_back(console_step(in_tuser[0], in_tdata[7:0], in_tdata[18:8]));
      end
      pending <= awaited.size();
    end
  end

endmodule

>>> bench/text_console_cell_writer_top_tb.sv
// Testbench top for the text console cell writer: clock, reset, stimulus, receiver stalls and verdict.
module text_console_cell_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tccw_pkg::*;

  localparam int COLUMNS = DEF_COLUMNS;
  localparam int ROWS    = DEF_ROWS;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int LIMIT   = 400000;

  localparam logic [CFG_AW-1:0] COLOR_ADDR     = CFG_AW'(4 * int'(REG_IDX_TEXT_COLOR));
  localparam int                UNUSED_REG_IDX = int'(REG_IDX_TEXT_COLOR) + 1;
  localparam logic [CFG_AW-1:0] SPARE_ADDR     = CFG_AW'(4 * UNUSED_REG_IDX);

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata    = '0;
  logic [0:0]        in_tuser    = '0;
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [31:0]       out_tdata;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [31:0]       cfg_pwdata  = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int          gap_pct    = 0;
  int          stall_pct  = 0;
  int          stall_left = 0;
  int          fail_count;
  int          pending;
  int unsigned cycles     = 0;

  text_console_cell_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) uut (.*);

  text_console_cell_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready,
    .mismatches(fail_count), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("text_console_cell_writer_top_tb: FAIL");
      $finish;
    end
  end

  // Receiver back-pressure: random bursts of stalled cycles with out_tready low.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic offer_item(input logic op, input logic [7:0] ch, input logic [10:0] idx);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, idx, ch};
    do @(posedge clk); while (!in_tready);
  endtask

  // Holds the input off until every outstanding result beat has been taken.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic apb_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  initial begin : stimulus
    int p;
    int n;
    int items;
    int nl_pct;
    int rd_pct;
    logic [7:0]  colour;
    logic [7:0]  ch;
    logic [10:0] idx;
    logic        op;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // The block clears its store after reset with in_tready low.
    do @(posedge clk); while (!(rst_n && in_tready));

    // Reads at both ends of the store and beyond it, against reset contents; then puts, reads.
    offer_item(OP_READ, 8'h00, 11'd0);
    offer_item(OP_READ, 8'hFF, 11'(CELLS - 1));
    offer_item(OP_READ, 8'h00, 11'(CELLS));
    offer_item(OP_READ, 8'hFF, 11'h7FF);
    offer_item(OP_PUT, 8'h00, 11'd0);
    offer_item(OP_PUT, 8'hFF, 11'h7FF);
    offer_item(OP_PUT, 8'h41, 11'd0);
    offer_item(OP_PUT, NEWLINE_CODE, 11'd0);
    offer_item(OP_PUT, NEWLINE_CODE, 11'h555);
    offer_item(OP_READ, 8'h00, 11'd0);
    offer_item(OP_READ, 8'h00, 11'd1);
    offer_item(OP_READ, 8'h00, 11'd2);
    offer_item(OP_READ, 8'h00, 11'(COLUMNS));
    drain();
    apb_access(1'b1, COLOR_ADDR, 32'h0000_00FF);
    apb_access(1'b1, SPARE_ADDR, 32'h0000_00A5);
    apb_access(1'b0, COLOR_ADDR, 32'h0);
    offer_item(OP_PUT, 8'h7E, 11'h2AA);
    offer_item(OP_READ, 8'h7E, 11'(2 * COLUMNS));
    offer_item(OP_READ, 8'h00, 11'(2 * COLUMNS + 1));
    drain();
    // Only the low byte of the write data is the attribute.
    apb_access(1'b1, COLOR_ADDR, 32'hFFFF_FF00);
    offer_item(OP_PUT, 8'h20, 11'd0);
    offer_item(OP_READ, 8'h00, 11'(2 * COLUMNS + 1));

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin items = 60;  nl_pct = 12; rd_pct = 25; gap_pct = 30; stall_pct = 8;
                 colour = 8'h00; end
        // Long lines without newlines, so that the cursor wraps at the line end.
        1: begin items = 140; nl_pct = 0;  rd_pct = 5;  gap_pct = 0;  stall_pct = 0;
                 colour = 8'($urandom_range(0, 255)); end
        2: begin items = 60;  nl_pct = 50; rd_pct = 20; gap_pct = 20; stall_pct = 20;
                 colour = 8'h1F; end
        3: begin items = 60;  nl_pct = 5;  rd_pct = 40; gap_pct = 50; stall_pct = 5;
                 colour = 8'hFF; end
        4: begin items = 60;  nl_pct = 40; rd_pct = 50; gap_pct = 25; stall_pct = 12;
                 colour = 8'($urandom_range(0, 255)); end
        default: begin items = 60; nl_pct = 20; rd_pct = 30; gap_pct = 0; stall_pct = 0;
                 colour = 8'h4E; end
      endcase
      drain();
      apb_access(1'b1, COLOR_ADDR, {24'b0, colour});
      apb_access(1'b0, COLOR_ADDR, 32'h0);
      for (n = 0; n < items; n++) begin
        op = ($urandom_range(0, 99) < rd_pct) ? OP_READ : OP_PUT;
        ch = ($urandom_range(0, 99) < nl_pct) ? NEWLINE_CODE : 8'($urandom_range(0, 255));
        // Short lines leave text in the first columns, so bias many reads there.
        case ($urandom_range(0, 3))
          0: idx = 11'($urandom_range(0, 2047));
          1: idx = 11'($urandom_range(0, ROWS - 1) * COLUMNS + $urandom_range(0, 15));
          2: idx = 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
          default: idx = 11'($urandom_range(0, CELLS - 1));
        endcase
        offer_item(op, ch, idx);
      end
    end

    drain();
    repeat (COLUMNS + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("text_console_cell_writer_top_tb: PASS");
    end else begin
      $display("text_console_cell_writer_top_tb: FAIL");
    end
    $finish;
  end

endmodule
